/* design/u2g_pkg.sv */
// Shared types, codes and constants of the UTF-8 to glyph mapper.
// Used by the cell modules and the top level; depends on nothing.
`default_nettype none

package u2g_pkg;

    // Default table depths.
    localparam int DEF_GLYPH_ENTRIES = 128;
    localparam int DEF_SUBST_ENTRIES = 32;

    // Input function codes.
    localparam logic [1:0] FUNC_TEXT     = 2'd0;
    localparam logic [1:0] FUNC_GLYPH_WR = 2'd1;
    localparam logic [1:0] FUNC_SUBST_WR = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SYM_START    = 3'd0;
    localparam logic [2:0] CFG_LANG_START   = 3'd1;
    localparam logic [2:0] CFG_GE_GLYPH     = 3'd2;
    localparam logic [2:0] CFG_DEGREE_GLYPH = 3'd3;
    localparam logic [2:0] CFG_GLYPH_COUNT  = 3'd4;
    localparam logic [2:0] CFG_SUBST_COUNT  = 3'd5;

    // Configuration reset values.
    localparam logic [7:0] RST_SYM_START  = 8'd128;
    localparam logic [7:0] RST_LANG_START = 8'd160;

    // Special code points and glyphs.
    localparam logic [15:0] CP_GREATER_EQUAL = 16'h2265;
    localparam logic [15:0] CP_DEGREE        = 16'h00B0;
    localparam logic [7:0]  GLYPH_SPACE      = 8'h20;

    // UTF-8 lead byte masks and patterns.
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;

    // Control states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_SUBST,
        ST_GLYPH,
        ST_EMIT
    } t_state;

    // Search token travelling down the substitution chain.
    typedef struct packed {
        logic        valid;
        logic        hit;
        logic [15:0] code;
        logic [15:0] repl;
    } t_sub_tok;

    // Search token travelling down the glyph chain.
    typedef struct packed {
        logic        valid;
        logic        hit;
        logic [15:0] code;
        logic [7:0]  idx;
    } t_gly_tok;

endpackage : u2g_pkg

`default_nettype wire

/* design/u2g_subst_cell.sv */
// One cell of the substitution chain: holds one key/replacement pair.
// Depends on u2g_pkg for the token type.
`default_nettype none

module u2g_subst_cell #(
    parameter int INDEX = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_we,
    input  wire logic [6:0]        i_wr_index,
    input  wire logic [15:0]       i_wr_code,
    input  wire logic [15:0]       i_wr_repl,
    input  wire logic [5:0]        i_count,
    input  wire u2g_pkg::t_sub_tok i_tok,
    output u2g_pkg::t_sub_tok      o_tok
);

    logic [15:0]       r_key;
    logic [15:0]       r_value;
    u2g_pkg::t_sub_tok r_tok;
    u2g_pkg::t_sub_tok n_tok;
    logic              w_active;

    // The cell takes part in the search only while it lies below the pair count.
    assign w_active = (7'(INDEX) < {1'b0, i_count});

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && !i_tok.hit && w_active && (r_key == i_tok.code)) begin
            n_tok.hit  = 1'b1;
            n_tok.repl = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_wr_index == 7'(INDEX))) begin
            r_key   <= i_wr_code;
            r_value <= i_wr_repl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule : u2g_subst_cell

`default_nettype wire

/* design/u2g_glyph_cell.sv */
// One cell of the glyph chain: holds one glyph table code point.
// Depends on u2g_pkg for the token type.
`default_nettype none

module u2g_glyph_cell #(
    parameter int INDEX = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_we,
    input  wire logic [6:0]        i_wr_index,
    input  wire logic [15:0]       i_wr_code,
    input  wire logic [7:0]        i_count,
    input  wire u2g_pkg::t_gly_tok i_tok,
    output u2g_pkg::t_gly_tok      o_tok
);

    logic [15:0]       r_code;
    u2g_pkg::t_gly_tok r_tok;
    u2g_pkg::t_gly_tok n_tok;
    logic              w_active;

    assign w_active = (9'(INDEX) < {1'b0, i_count});

    // First match wins: a token that already hit passes through untouched.
    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && !i_tok.hit && w_active && (r_code == i_tok.code)) begin
            n_tok.hit = 1'b1;
            n_tok.idx = 8'(INDEX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && ({2'b00, i_wr_index} == 9'(INDEX))) begin
            r_code <= i_wr_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule : u2g_glyph_cell

`default_nettype wire

/* design/utf8_to_glyph_mapper_unit.sv */
// Top level of the UTF-8 to glyph mapper: decoder, control and the two cell chains.
// Depends on u2g_pkg, u2g_subst_cell and u2g_glyph_cell.
`default_nettype none

// The block takes one transaction at a time on its input channel. A text byte
// that completes nothing, or a table write, leaves the block idle. A single
// byte or a truncated sequence goes to the emit state, and its glyph is loaded
// into the output register once that register is free; the block is idle
// again as the glyph is loaded. A completed multi-byte sequence that hits the
// symbol range or one of the two fixed characters passes through the map and
// emit states before its glyph reaches the output register. Otherwise its
// search token walks the substitution chain, one cell per cycle, and then, if
// needed, the glyph chain in the same way, before the emit state. The next
// transaction is taken once the glyph has moved into the output register, so
// while an earlier glyph still waits there, the block stays in its emit state.
// The table contents live in the cells themselves and are written through the
// input port with func 1 and 2; reading a slot that was never written gives
// an unspecified glyph. The output sits in its own register, so the next
// transaction is accepted while a finished glyph still waits to be taken.
// Configuration registers are written through the plain write port and must
// only change while the block is idle.
module utf8_to_glyph_mapper_unit #(
    parameter int GLYPH_ENTRIES = u2g_pkg::DEF_GLYPH_ENTRIES,
    parameter int SUBST_ENTRIES = u2g_pkg::DEF_SUBST_ENTRIES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data,
    // Input channel.
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_last_byte,
    input  wire logic [6:0]  i_entry_index,
    input  wire logic [15:0] i_entry_code,
    input  wire logic [15:0] i_entry_replacement,
    // Output channel.
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_glyph
);

    // Configuration registers.
    logic [7:0] r_sym_start;
    logic [7:0] r_lang_start;
    logic [7:0] r_ge_glyph;
    logic [7:0] r_degree_glyph;
    logic [7:0] r_glyph_count;
    logic [5:0] r_subst_count;

    // Decoder and control state. r_partial holds code point bits 15:6; the low
    // six bits always come from the final byte.
    u2g_pkg::t_state r_state, n_state;
    logic [9:0]      r_partial, n_partial;
    logic [1:0]      r_pending, n_pending;
    logic [15:0]     r_cp, n_cp;
    logic [7:0]      r_res, n_res;

    // Output register.
    logic       r_out_valid;
    logic [7:0] r_out_glyph;

    // Handshake and chain control.
    logic              w_in_fire;
    logic              w_emit;
    logic              w_glyph_we;
    logic              w_subst_we;
    logic              w_in_sym;
    logic              w_is_ge;
    logic              w_is_deg;
    logic              w_lead2;
    logic              w_lead3;
    logic [15:0]       w_subst_code;
    logic              w_need_table;
    u2g_pkg::t_sub_tok w_sub_tok [0:SUBST_ENTRIES];
    u2g_pkg::t_gly_tok w_gly_tok [0:GLYPH_ENTRIES];

    assign w_in_fire = i_in_valid && o_in_ready;

    // Configuration writes. Indexes beyond the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_start    <= u2g_pkg::RST_SYM_START;
            r_lang_start   <= u2g_pkg::RST_LANG_START;
            r_ge_glyph     <= '0;
            r_degree_glyph <= '0;
            r_glyph_count  <= '0;
            r_subst_count  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                u2g_pkg::CFG_SYM_START:    r_sym_start    <= i_cfg_data;
                u2g_pkg::CFG_LANG_START:   r_lang_start   <= i_cfg_data;
                u2g_pkg::CFG_GE_GLYPH:     r_ge_glyph     <= i_cfg_data;
                u2g_pkg::CFG_DEGREE_GLYPH: r_degree_glyph <= i_cfg_data;
                u2g_pkg::CFG_GLYPH_COUNT:  r_glyph_count  <= i_cfg_data;
                u2g_pkg::CFG_SUBST_COUNT:  r_subst_count  <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Lead byte classes. Four-byte leads fall into neither and pass through.
    assign w_lead2 = ((i_text_byte & u2g_pkg::LEAD2_MASK) == u2g_pkg::LEAD2_PAT);
    assign w_lead3 = ((i_text_byte & u2g_pkg::LEAD3_MASK) == u2g_pkg::LEAD3_PAT);

    // Checks on the assembled code point that bypass both tables.
    assign w_in_sym = (r_cp >= {8'd0, r_sym_start}) && (r_cp < {8'd0, r_lang_start});
    assign w_is_ge  = (r_cp == u2g_pkg::CP_GREATER_EQUAL);
    assign w_is_deg = (r_cp == u2g_pkg::CP_DEGREE);

    // Result of the substitution search, and whether it goes on to the glyph table.
    assign w_subst_code = w_sub_tok[SUBST_ENTRIES].hit ? w_sub_tok[SUBST_ENTRIES].repl : r_cp;
    assign w_need_table = (w_subst_code > {8'd0, r_lang_start});

    // Next state and datapath.
    always_comb begin
        n_state   = r_state;
        n_partial = r_partial;
        n_pending = r_pending;
        n_cp      = r_cp;
        n_res     = r_res;
        case (r_state)
            u2g_pkg::ST_IDLE: begin
                if (w_in_fire && (i_func == u2g_pkg::FUNC_TEXT)) begin
                    if (r_pending == 2'd2) begin
                        // Middle byte of a three-byte sequence.
                        n_partial[5:0] = i_text_byte[5:0];
                        n_pending      = 2'd1;
                        if (i_last_byte) begin
                            n_pending = 2'd0;
                            n_partial = '0;
                            n_res     = '0;
                            n_state   = u2g_pkg::ST_EMIT;
                        end
                    end else if (r_pending != 2'd0) begin
                        // Final byte: the code point is complete.
                        n_cp      = {r_partial, i_text_byte[5:0]};
                        n_pending = 2'd0;
                        n_partial = '0;
                        n_state   = u2g_pkg::ST_MAP;
                    end else if (w_lead2 || w_lead3) begin
                        if (i_last_byte) begin
                            n_res   = '0;
                            n_state = u2g_pkg::ST_EMIT;
                        end else if (w_lead2) begin
                            n_partial = {5'd0, i_text_byte[4:0]};
                            n_pending = 2'd1;
                        end else begin
                            n_partial = {i_text_byte[3:0], 6'd0};
                            n_pending = 2'd2;
                        end
                    end else begin
                        n_res   = i_text_byte;
                        n_state = u2g_pkg::ST_EMIT;
                    end
                end
            end
            u2g_pkg::ST_MAP: begin
                if (w_in_sym) begin
                    n_res   = r_cp[7:0];
                    n_state = u2g_pkg::ST_EMIT;
                end else if (w_is_ge) begin
                    n_res   = r_ge_glyph;
                    n_state = u2g_pkg::ST_EMIT;
                end else if (w_is_deg) begin
                    n_res   = r_degree_glyph;
                    n_state = u2g_pkg::ST_EMIT;
                end else begin
                    n_state = u2g_pkg::ST_SUBST;
                end
            end
            u2g_pkg::ST_SUBST: begin
                if (w_sub_tok[SUBST_ENTRIES].valid) begin
                    n_cp  = w_subst_code;
                    n_res = w_subst_code[7:0];
                    if (w_need_table && (r_glyph_count != 8'd0)) begin
                        n_state = u2g_pkg::ST_GLYPH;
                    end else begin
                        n_state = u2g_pkg::ST_EMIT;
                    end
                end
            end
            u2g_pkg::ST_GLYPH: begin
                if (w_gly_tok[GLYPH_ENTRIES].valid) begin
                    if (w_gly_tok[GLYPH_ENTRIES].hit) begin
                        n_res = r_lang_start + w_gly_tok[GLYPH_ENTRIES].idx;
                    end else begin
                        n_res = u2g_pkg::GLYPH_SPACE;
                    end
                    n_state = u2g_pkg::ST_EMIT;
                end
            end
            u2g_pkg::ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = u2g_pkg::ST_IDLE;
                end
            end
            default: n_state = u2g_pkg::ST_IDLE;
        endcase
    end

    // Control outputs: handshake, table writes and token launches.
    always_comb begin
        o_in_ready = (r_state == u2g_pkg::ST_IDLE);
        w_emit     = (r_state == u2g_pkg::ST_EMIT) && (!r_out_valid || i_out_ready);
        w_glyph_we = w_in_fire && (i_func == u2g_pkg::FUNC_GLYPH_WR);
        w_subst_we = w_in_fire && (i_func == u2g_pkg::FUNC_SUBST_WR);

        w_sub_tok[0].valid = (r_state == u2g_pkg::ST_MAP) && !w_in_sym && !w_is_ge && !w_is_deg;
        w_sub_tok[0].hit   = 1'b0;
        w_sub_tok[0].code  = r_cp;
        w_sub_tok[0].repl  = r_cp;

        w_gly_tok[0].valid = (r_state == u2g_pkg::ST_SUBST) && w_sub_tok[SUBST_ENTRIES].valid
                             && w_need_table && (r_glyph_count != 8'd0);
        w_gly_tok[0].hit   = 1'b0;
        w_gly_tok[0].code  = w_subst_code;
        w_gly_tok[0].idx   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= u2g_pkg::ST_IDLE;
            r_partial <= '0;
            r_pending <= '0;
        end else begin
            r_state   <= n_state;
            r_partial <= n_partial;
            r_pending <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp  <= n_cp;
        r_res <= n_res;
    end

    // Output register: loaded from the result once the previous glyph is gone.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_glyph <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_glyph     = r_out_glyph;

    // Substitution chain: one key/replacement pair per cell.
    for (genvar g = 0; g < SUBST_ENTRIES; g++) begin : g_subst
        u2g_subst_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_we       (w_subst_we),
            .i_wr_index (i_entry_index),
            .i_wr_code  (i_entry_code),
            .i_wr_repl  (i_entry_replacement),
            .i_count    (r_subst_count),
            .i_tok      (w_sub_tok[g]),
            .o_tok      (w_sub_tok[g+1])
        );
    end

    // Glyph chain: one table entry per cell.
    for (genvar g = 0; g < GLYPH_ENTRIES; g++) begin : g_glyph
        u2g_glyph_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_we       (w_glyph_we),
            .i_wr_index (i_entry_index),
            .i_wr_code  (i_entry_code),
            .i_count    (r_glyph_count),
            .i_tok      (w_gly_tok[g]),
            .o_tok      (w_gly_tok[g+1])
        );
    end

endmodule : utf8_to_glyph_mapper_unit

`default_nettype wire

/* tb/utf8_to_glyph_mapper_unit_tb.sv */
// Self-checking testbench for utf8_to_glyph_mapper_unit: UTF-8 text decode and glyph lookup.
// Depends on u2g_pkg and the block itself; nothing else.
`timescale 1ns / 1ps

module utf8_to_glyph_mapper_unit_tb;

    localparam int GLYPHS = u2g_pkg::DEF_GLYPH_ENTRIES;
    localparam int SUBSTS = u2g_pkg::DEF_SUBST_ENTRIES;

    // The fourth function code has no meaning and must leave the block untouched.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Worst-case search time of one character, plus some margin.
    localparam int SETTLE_CYCLES = SUBSTS + GLYPHS + 16;
    localparam int DRAIN_LIMIT   = 200000;

    // One input transaction, field for field as the block takes it.
    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  text_byte;
        logic        last_byte;
        logic [6:0]  entry_index;
        logic [15:0] entry_code;
        logic [15:0] entry_replacement;
    } t_mapper_req;

    // Keeps a private copy of the decoder state, the two tables and the
    // mapping registers, and from them works out which glyph each accepted
    // transaction should produce.
    class t_glyph_checker;
        logic [7:0]  sym_start;
        logic [7:0]  lang_start;
        logic [7:0]  ge_glyph;
        logic [7:0]  degree_glyph;
        logic [7:0]  glyph_count;
        logic [5:0]  subst_count;
        logic [15:0] partial;
        logic [1:0]  cont_left;
        logic [15:0] glyph_codes [GLYPHS];
        logic [15:0] subst_keys  [SUBSTS];
        logic [15:0] subst_vals  [SUBSTS];
        logic [7:0]  glyphs_due [$];
        int          errors;

        function new();
            sym_start    = u2g_pkg::RST_SYM_START;
            lang_start   = u2g_pkg::RST_LANG_START;
            ge_glyph     = '0;
            degree_glyph = '0;
            glyph_count  = '0;
            subst_count  = '0;
            partial      = '0;
            cont_left    = '0;
            errors       = 0;
            foreach (glyph_codes[k]) glyph_codes[k] = '0;
            foreach (subst_keys[k]) begin
                subst_keys[k] = '0;
                subst_vals[k] = '0;
            end
        endfunction

        function void set_reg(logic [2:0] idx, logic [7:0] data);
            case (idx)
                u2g_pkg::CFG_SYM_START:    sym_start    = data;
                u2g_pkg::CFG_LANG_START:   lang_start   = data;
                u2g_pkg::CFG_GE_GLYPH:     ge_glyph     = data;
                u2g_pkg::CFG_DEGREE_GLYPH: degree_glyph = data;
                u2g_pkg::CFG_GLYPH_COUNT:  glyph_count  = data;
                u2g_pkg::CFG_SUBST_COUNT:  subst_count  = data[5:0];
                default: ;
            endcase
        endfunction

        function logic [15:0] substitute(logic [15:0] cp);
            int n;
            int i;
            n = (subst_count < SUBSTS) ? subst_count : SUBSTS;
            for (i = 0; i < n; i++)
                if (subst_keys[i] == cp)
                    return subst_vals[i];
            return cp;
        endfunction

        function logic [7:0] search_glyph(logic [15:0] cp);
            int n;
            int i;
            if (glyph_count == 0)
                return cp[7:0];
            n = (glyph_count < GLYPHS) ? glyph_count : GLYPHS;
            for (i = 0; i < n; i++)
                if (glyph_codes[i] == cp)
                    return lang_start + i[7:0];
            return u2g_pkg::GLYPH_SPACE;
        endfunction

        function logic [7:0] map_code(logic [15:0] cp);
            logic [15:0] m;
            if (cp >= sym_start && cp < lang_start)
                return cp[7:0];
            if (cp == u2g_pkg::CP_GREATER_EQUAL)
                return ge_glyph;
            if (cp == u2g_pkg::CP_DEGREE)
                return degree_glyph;
            m = substitute(cp);
            if (m > lang_start)
                return search_glyph(m);
            return m[7:0];
        endfunction

        function void decode_byte(logic [7:0] b, logic is_last);
            logic [15:0] cp;
            if (cont_left == 2'd2) begin
                partial[11:6] = partial[11:6] | b[5:0];
                cont_left = 2'd1;
                if (is_last) begin
                    // A three-byte sequence cut after its second byte.
                    cont_left = '0;
                    partial   = '0;
                    glyphs_due.push_back(8'h00);
                end
            end else if (cont_left != 0) begin
                cp = partial | {10'd0, b[5:0]};
                cont_left = '0;
                partial   = '0;
                glyphs_due.push_back(map_code(cp));
            end else if ((b & u2g_pkg::LEAD2_MASK) == u2g_pkg::LEAD2_PAT
                         || (b & u2g_pkg::LEAD3_MASK) == u2g_pkg::LEAD3_PAT) begin
                if (is_last) begin
                    glyphs_due.push_back(8'h00);
                end else if ((b & u2g_pkg::LEAD2_MASK) == u2g_pkg::LEAD2_PAT) begin
                    partial   = {5'd0, b[4:0], 6'd0};
                    cont_left = 2'd1;
                end else begin
                    partial   = {b[3:0], 12'd0};
                    cont_left = 2'd2;
                end
            end else begin
                glyphs_due.push_back(b);
            end
        endfunction

        function void note_request(t_mapper_req req);
            case (req.func)
                u2g_pkg::FUNC_GLYPH_WR: begin
                    if (int'(req.entry_index) < GLYPHS)
                        glyph_codes[req.entry_index] = req.entry_code;
                end
                u2g_pkg::FUNC_SUBST_WR: begin
                    if (int'(req.entry_index) < SUBSTS) begin
                        subst_keys[req.entry_index] = req.entry_code;
                        subst_vals[req.entry_index] = req.entry_replacement;
                    end
                end
                u2g_pkg::FUNC_TEXT: decode_byte(req.text_byte, req.last_byte);
                default: ;
            endcase
        endfunction

        function void check_glyph(logic [7:0] got);
            logic [7:0] want;
            if (glyphs_due.size() == 0) begin
                $display("%0t: glyph with none expected, expected none, actual %02h",
                         $time, got);
                errors++;
                return;
            end
            want = glyphs_due.pop_front();
            if (got !== want) begin
                $display("%0t: glyph mismatch, expected %02h, actual %02h", $time, want, got);
                errors++;
            end
        endfunction

        function int pending();
            return glyphs_due.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [7:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_func;
    logic [7:0]  i_text_byte;
    logic        i_last_byte;
    logic [6:0]  i_entry_index;
    logic [15:0] i_entry_code;
    logic [15:0] i_entry_replacement;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_glyph;

    t_glyph_checker chk = new();

    // Sender pacing: transactions go out in bursts, with idle gaps between
    // bursts. In a steady phase the gaps are zero and valid stays high.
    int burst_left = 0;
    bit steady_sender = 1'b0;

    utf8_to_glyph_mapper_unit uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_func              (i_func),
        .i_text_byte         (i_text_byte),
        .i_last_byte         (i_last_byte),
        .i_entry_index       (i_entry_index),
        .i_entry_code        (i_entry_code),
        .i_entry_replacement (i_entry_replacement),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_glyph             (o_glyph)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard limit on the whole run, several times the slowest legal run.
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // The receiver picks a stall pattern, keeps it for a random stretch, and
    // moves on: always ready, coin flip, mostly stalled, or mostly ready.
    initial begin
        int mode;
        i_out_ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 300)) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= 1'($urandom_range(0, 1));
                    2:       i_out_ready <= ($urandom_range(0, 7) == 0);
                    default: i_out_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Every glyph transaction on the output side is checked against the
    // oldest outstanding prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            chk.check_glyph(o_glyph);
    end

    // Offers one transaction and holds it until the block takes it. The
    // prediction is made at the very edge that accepts the transaction.
    task automatic send_req(input t_mapper_req req);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady_sender ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid          <= 1'b1;
        i_func              <= req.func;
        i_text_byte         <= req.text_byte;
        i_last_byte         <= req.last_byte;
        i_entry_index       <= req.entry_index;
        i_entry_code        <= req.entry_code;
        i_entry_replacement <= req.entry_replacement;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        chk.note_request(req);
    endtask

    // Text byte; the table fields are don't-care here, so they carry noise.
    task automatic send_text(input logic [7:0] b, input logic is_last);
        t_mapper_req req;
        req.func              = u2g_pkg::FUNC_TEXT;
        req.text_byte         = b;
        req.last_byte         = is_last;
        req.entry_index       = 7'($urandom);
        req.entry_code        = 16'($urandom);
        req.entry_replacement = 16'($urandom);
        send_req(req);
    endtask

    task automatic send_table(input logic [1:0] func, input logic [6:0] idx,
                              input logic [15:0] code, input logic [15:0] repl);
        t_mapper_req req;
        req.func              = func;
        req.text_byte         = 8'($urandom);
        req.last_byte         = 1'($urandom);
        req.entry_index       = idx;
        req.entry_code        = code;
        req.entry_replacement = repl;
        send_req(req);
    endtask

    // Code points are drawn mostly from a narrow band, so that text, glyph
    // entries and substitution keys collide often; the rest cover the
    // symbol range, the two fixed characters and the whole 16-bit space.
    function automatic logic [15:0] pick_code();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return 16'h0400 + 16'($urandom_range(0, 31));
        if (sel < 55)
            return 16'($urandom_range(0, 255));
        if (sel < 60)
            return u2g_pkg::CP_GREATER_EQUAL;
        if (sel < 65)
            return u2g_pkg::CP_DEGREE;
        if (sel < 75)
            return 16'($urandom_range(0, 16'h07FF));
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    // Replacements that land at or below lang_start skip the glyph search.
    function automatic logic [15:0] pick_repl();
        if ($urandom_range(0, 1) == 0)
            return 16'($urandom_range(0, 255));
        return pick_code();
    endfunction

    // Encodes one code point as a two- or three-byte sequence. Overlong forms
    // are fine, and the top bits of the final byte are sometimes scrambled,
    // since continuation bytes are not checked.
    task automatic send_char(input logic [15:0] cp, input logic is_last);
        logic [1:0] top;
        top = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 3)) : 2'b10;
        if (cp < 16'h0800 && $urandom_range(0, 3) != 0) begin
            send_text({3'b110, cp[10:6]}, 1'b0);
            send_text({top, cp[5:0]}, is_last);
        end else begin
            send_text({4'b1110, cp[15:12]}, 1'b0);
            send_text({2'b10, cp[11:6]}, 1'b0);
            send_text({top, cp[5:0]}, is_last);
        end
    endtask

    // A sequence broken off by the end-of-string flag.
    task automatic send_cut_char();
        logic [15:0] cp;
        int sel;
        cp  = pick_code();
        sel = $urandom_range(0, 2);
        if (sel == 0) begin
            send_text({3'b110, cp[10:6]}, 1'b1);
        end else if (sel == 1) begin
            send_text({4'b1110, cp[15:12]}, 1'b1);
        end else begin
            send_text({4'b1110, cp[15:12]}, 1'b0);
            send_text({2'b10, cp[11:6]}, 1'b1);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        chk.set_reg(idx, data);
    endtask

    task automatic set_mapping(input logic [7:0] sym, input logic [7:0] lang,
                               input logic [7:0] ge, input logic [7:0] deg,
                               input logic [7:0] gcount, input logic [7:0] scount);
        write_reg(u2g_pkg::CFG_SYM_START, sym);
        write_reg(u2g_pkg::CFG_LANG_START, lang);
        write_reg(u2g_pkg::CFG_GE_GLYPH, ge);
        write_reg(u2g_pkg::CFG_DEGREE_GLYPH, deg);
        write_reg(u2g_pkg::CFG_GLYPH_COUNT, gcount);
        write_reg(u2g_pkg::CFG_SUBST_COUNT, scount);
    endtask

    // Stops sending, waits for every predicted glyph, then lets the block
    // finish any search or write that produces no glyph of its own.
    task automatic drain_glyphs();
        int spins;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        spins = 0;
        while (chk.pending() != 0 && spins < DRAIN_LIMIT) begin
            @(posedge i_clk);
            spins++;
        end
        if (chk.pending() != 0) begin
            $display("%0t: %0d glyphs never arrived", $time, chk.pending());
            chk.errors++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Runs with both counts at zero, so no table slot is ever read.
    task automatic run_directed();
        send_text(8'h00, 1'b0);
        send_text(8'h7F, 1'b0);
        send_text(8'hFF, 1'b1);          // not a lead, so the end flag changes nothing
        send_text(8'h80, 1'b0);          // stray continuation byte
        send_text(8'hF0, 1'b0);          // four-byte lead passes through
        send_text(8'hC2, 1'b0);          // degree sign
        send_text(8'hB0, 1'b0);
        send_text(8'hE2, 1'b0);          // greater-or-equal, final byte flagged last
        send_text(8'h89, 1'b0);
        send_text(8'hA5, 1'b1);
        send_text(8'hC3, 1'b1);          // lead flagged last
        send_text(8'hE2, 1'b0);          // cut after the second byte
        send_text(8'h89, 1'b1);
        send_text(8'hC2, 1'b0);          // symbol range, with a table write inside
        send_table(u2g_pkg::FUNC_GLYPH_WR, 7'd5, 16'h1234, 16'h0000);
        send_text(8'h85, 1'b0);
        send_text(8'hC2, 1'b0);          // unused function inside, the next byte still ends the sequence
        send_table(FUNC_UNUSED, 7'd0, 16'h2265, 16'h0041);
        send_text(8'h41, 1'b0);
        send_text(8'hD0, 1'b0);          // above lang_start with no glyph table
        send_text(8'h96, 1'b0);
        send_table(u2g_pkg::FUNC_SUBST_WR, 7'd127, 16'hFFFF, 16'h0041);  // slot outside the table
        send_text(8'hEF, 1'b0);          // highest code point
        send_text(8'hFF, 1'b0);
        send_text(8'hFF, 1'b0);
    endtask

    // Fills every slot of both tables, so later searches never touch an
    // entry that was not written.
    task automatic load_tables();
        int k;
        for (k = 0; k < GLYPHS; k++)
            send_table(u2g_pkg::FUNC_GLYPH_WR, k[6:0], pick_code(), 16'($urandom));
        for (k = 0; k < SUBSTS; k++)
            send_table(u2g_pkg::FUNC_SUBST_WR, k[6:0], pick_code(), pick_repl());
    endtask

    // Mostly well-formed characters, with noise bytes, cut sequences, table
    // rewrites and the unused function mixed in.
    task automatic run_random(input int units);
        int kind;
        logic [6:0] slot;
        repeat (units) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                send_char(pick_code(), $urandom_range(0, 9) == 0);
            end else if (kind < 70) begin
                send_text(8'($urandom), $urandom_range(0, 9) == 0);
            end else if (kind < 78) begin
                send_cut_char();
            end else if (kind < 86) begin
                send_table(u2g_pkg::FUNC_GLYPH_WR, 7'($urandom), pick_code(), 16'($urandom));
            end else if (kind < 95) begin
                slot = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                   : 7'($urandom_range(0, SUBSTS - 1));
                send_table(u2g_pkg::FUNC_SUBST_WR, slot, pick_code(), pick_repl());
            end else begin
                send_table(FUNC_UNUSED, 7'($urandom), 16'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        int phase;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = '0;
        i_cfg_data          = '0;
        i_in_valid          = 1'b0;
        i_func              = u2g_pkg::FUNC_TEXT;
        i_text_byte         = '0;
        i_last_byte         = 1'b0;
        i_entry_index       = '0;
        i_entry_code        = '0;
        i_entry_replacement = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        drain_glyphs();
        load_tables();
        drain_glyphs();

        // Each phase sets all six registers, then streams random text. The
        // drain at the end of a phase is also where the sender holds off
        // until every predicted glyph has been taken.
        for (phase = 0; phase < 6; phase++) begin
            steady_sender = (phase == 1 || phase == 4);
            case (phase)
                0: set_mapping(8'd128, 8'd160, 8'h3E, 8'h7E, 8'd128, 8'd32);
                1: set_mapping(8'd0, 8'd255, 8'd0, 8'd255, 8'd1, 8'd1);
                // Both counts above the table sizes must saturate.
                2: set_mapping(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd63);
                // Empty symbol range and no tables at all.
                3: set_mapping(8'd128, 8'd128, 8'($urandom), 8'($urandom), 8'd0, 8'd0);
                default: set_mapping(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                     8'($urandom_range(0, GLYPHS)),
                                     8'($urandom_range(0, SUBSTS)));
            endcase
            run_random(100);
            drain_glyphs();
        end

        if (chk.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
design/u2g_pkg.sv
design/u2g_subst_cell.sv
design/u2g_glyph_cell.sv
design/utf8_to_glyph_mapper_unit.sv
tb/utf8_to_glyph_mapper_unit_tb.sv
